FILE: rtl/pidbc_pkg.sv
// ----------------------------------------------------------------------------
// pidbc_pkg
// shared types, constants and saturation helpers of the pid unit
// ----------------------------------------------------------------------------
package pidbc_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned GAIN_W        = 31;
  localparam int unsigned ADDR_W        = 5;

  localparam logic [2:0] REG_GAIN_PROP     = 3'd0;
  localparam logic [2:0] REG_GAIN_INTEG    = 3'd1;
  localparam logic [2:0] REG_GAIN_DERIV    = 3'd2;
  localparam logic [2:0] REG_GAIN_BACKCALC = 3'd3;
  localparam logic [2:0] REG_TIME_STEP     = 3'd4;
  localparam logic [2:0] REG_DRIVE_MIN     = 3'd5;
  localparam logic [2:0] REG_DRIVE_MAX     = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_BC_MUL,
    ST_INC_MUL,
    ST_I_MUL,
    ST_P_MUL,
    ST_DIV,
    ST_D_MUL,
    ST_OUT
  } state_e;

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v[33:31] != {3{v[33]}}) begin
      r = v[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [33:0] s;
    s = 34'(a) + 34'(b);
    return sat34(s);
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [33:0] s;
    s = 34'(a) - 34'(b);
    return sat34(s);
  endfunction

endpackage

FILE: rtl/pidbc_if.sv
// ----------------------------------------------------------------------------
// pidbc channel interfaces
// valid/ready channels for sample beats in and drive beats out
// ----------------------------------------------------------------------------
interface pidbc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] target;
  logic signed [31:0] sensed;
  modport source (output valid, output target, output sensed, input ready);
  modport sink   (input valid, input target, input sensed, output ready);
endinterface

interface pidbc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive;
  logic               hit_high;
  logic               hit_low;
  modport source (output valid, output drive, output hit_high, output hit_low,
                  input ready);
  modport sink   (input valid, input drive, input hit_high, input hit_low,
                  output ready);
endinterface

FILE: rtl/pid_controller_back_calc_antiwindup_unit.sv
// ----------------------------------------------------------------------------
// pid_controller_back_calc_antiwindup_unit
// fixed-point pid loop with back-calculation anti-windup and output clamp
// ----------------------------------------------------------------------------
// One sample beat (target, sensed) yields one drive beat. The unit works on
// one sample at a time: five gain products go through one bit-serial
// multiplier and the derivative goes through a restoring divider, so a new
// sample is taken only after the previous one has passed the accept, error,
// product, divide and output steps, and the output step waits while the
// previous drive beat is held off. A finished drive beat waits in an output
// register while the next sample is taken. Registers are written over APB
// with pready tied high; write only while no sample is in flight.
module pid_controller_back_calc_antiwindup_unit #(
  parameter int unsigned FracBits = pidbc_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  pidbc_in_if.sink                      in_ch,
  pidbc_out_if.source                   out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pidbc_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import pidbc_pkg::*;

  state_e state_q, state_d;

  logic [GAIN_W-1:0]  gp_q, gi_q, gd_q, gbc_q, ts_q;
  logic signed [31:0] dmin_q, dmax_q;
  logic signed [31:0] accum_q, last_err_q, last_raw_q, last_clamp_q;
  logic signed [31:0] tgt_q, mes_q, err_q, wind_q, tmp_q, pterm_q, iterm_q, dterm_q;
  logic               busy_q;
  logic               out_valid_q;
  logic signed [31:0] out_drive_q;
  logic               out_hi_q, out_lo_q;

  logic               mul_start, mul_done, div_start, div_done;
  logic [GAIN_W-1:0]  mul_gain, dt;
  logic signed [31:0] mul_x, mul_res, div_res;
  logic signed [32:0] err_diff;
  logic signed [33:0] raw_sum;
  logic signed [31:0] raw, clamped;
  logic               hi, lo, wr_en, in_acc, out_free;

  assign dt       = (ts_q == '0) ? GAIN_W'(1) : ts_q;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_q || out_ch.ready;
  assign wr_en    = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign err_diff = 33'(err_q) - 33'(last_err_q);

  pidbc_mul #(.FracBits(FracBits)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .gain_i (mul_gain),
    .x_i    (mul_x),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  pidbc_div #(.FracBits(FracBits)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .diff_i (err_diff),
    .dt_i   (dt),
    .done_o (div_done),
    .res_o  (div_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (in_acc) state_d = ST_ERR;
      ST_ERR:     state_d = ST_BC_MUL;
      ST_BC_MUL:  if (mul_done) state_d = ST_INC_MUL;
      ST_INC_MUL: if (mul_done) state_d = ST_I_MUL;
      ST_I_MUL:   if (mul_done) state_d = ST_P_MUL;
      ST_P_MUL:   if (mul_done) state_d = ST_DIV;
      ST_DIV:     if (div_done) state_d = ST_D_MUL;
      ST_D_MUL:   if (mul_done) state_d = ST_OUT;
      ST_OUT:     if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ch.ready = (state_q == ST_IDLE);
    mul_start   = 1'b0;
    div_start   = 1'b0;
    mul_gain    = gbc_q;
    mul_x       = wind_q;
    case (state_q)
      ST_BC_MUL: begin
        mul_start = !busy_q;
      end
      ST_INC_MUL: begin
        mul_start = !busy_q;
        mul_gain  = dt;
        mul_x     = tmp_q;
      end
      ST_I_MUL: begin
        mul_start = !busy_q;
        mul_gain  = gi_q;
        mul_x     = accum_q;
      end
      ST_P_MUL: begin
        mul_start = !busy_q;
        mul_gain  = gp_q;
        mul_x     = err_q;
      end
      ST_DIV: begin
        div_start = !busy_q;
      end
      ST_D_MUL: begin
        mul_start = !busy_q;
        mul_gain  = gd_q;
        mul_x     = tmp_q;
      end
      default: begin
      end
    endcase
  end

  assign raw_sum = 34'(pterm_q) + 34'(iterm_q) + 34'(dterm_q);
  assign raw     = sat34(raw_sum);
  always_comb begin
    hi      = 1'b0;
    lo      = 1'b0;
    clamped = raw;
    if (raw > dmax_q) begin
      clamped = dmax_q;
      hi      = 1'b1;
    end else if (raw < dmin_q) begin
      clamped = dmin_q;
      lo      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      busy_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      gp_q         <= '0;
      gi_q         <= '0;
      gd_q         <= '0;
      gbc_q        <= '0;
      ts_q         <= GAIN_W'(1) << FracBits;
      dmin_q       <= '0;
      dmax_q       <= 32'sd1 <<< FracBits;
      accum_q      <= '0;
      last_err_q   <= '0;
      last_raw_q   <= '0;
      last_clamp_q <= '0;
    end else begin
      state_q <= state_d;
      if (mul_start || div_start) begin
        busy_q <= 1'b1;
      end else if (mul_done || div_done) begin
        busy_q <= 1'b0;
      end
      if (wr_en) begin
        case (paddr[ADDR_W-1:2])
          REG_GAIN_PROP:     gp_q   <= pwdata[GAIN_W-1:0];
          REG_GAIN_INTEG:    gi_q   <= pwdata[GAIN_W-1:0];
          REG_GAIN_DERIV:    gd_q   <= pwdata[GAIN_W-1:0];
          REG_GAIN_BACKCALC: gbc_q  <= pwdata[GAIN_W-1:0];
          REG_TIME_STEP:     ts_q   <= pwdata[GAIN_W-1:0];
          REG_DRIVE_MIN:     dmin_q <= pwdata;
          REG_DRIVE_MAX:     dmax_q <= pwdata;
          default: begin
          end
        endcase
      end
      if (state_q == ST_INC_MUL && mul_done) begin
        accum_q <= add_sat(accum_q, mul_res);
      end
      if (state_q == ST_DIV && div_done) begin
        last_err_q <= err_q;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q  <= 1'b1;
        last_raw_q   <= raw;
        last_clamp_q <= clamped;
      end else if (out_valid_q && out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tgt_q <= in_ch.target;
      mes_q <= in_ch.sensed;
    end
    if (state_q == ST_ERR) begin
      err_q  <= sub_sat(tgt_q, mes_q);
      wind_q <= sub_sat(last_clamp_q, last_raw_q);
    end
    if (mul_done) begin
      case (state_q)
        ST_BC_MUL: tmp_q   <= add_sat(err_q, mul_res);
        ST_I_MUL:  iterm_q <= mul_res;
        ST_P_MUL:  pterm_q <= mul_res;
        ST_D_MUL:  dterm_q <= mul_res;
        default: begin
        end
      endcase
    end
    if (state_q == ST_DIV && div_done) begin
      tmp_q <= div_res;
    end
    if (state_q == ST_OUT && out_free) begin
      out_drive_q <= clamped;
      out_hi_q    <= hi;
      out_lo_q    <= lo;
    end
  end

  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_GAIN_PROP:     prdata = {1'b0, gp_q};
      REG_GAIN_INTEG:    prdata = {1'b0, gi_q};
      REG_GAIN_DERIV:    prdata = {1'b0, gd_q};
      REG_GAIN_BACKCALC: prdata = {1'b0, gbc_q};
      REG_TIME_STEP:     prdata = {1'b0, ts_q};
      REG_DRIVE_MIN:     prdata = dmin_q;
      REG_DRIVE_MAX:     prdata = dmax_q;
      default:           prdata = '0;
    endcase
  end

  assign out_ch.valid    = out_valid_q;
  assign out_ch.drive    = out_drive_q;
  assign out_ch.hit_high = out_hi_q;
  assign out_ch.hit_low  = out_lo_q;

endmodule

FILE: rtl/pidbc_mul.sv
// ----------------------------------------------------------------------------
// pidbc_mul
// bit-serial gain multiplier, one gain bit per cycle, fixed-point rescale
// ----------------------------------------------------------------------------
module pidbc_mul #(
  parameter int unsigned FracBits = pidbc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [pidbc_pkg::GAIN_W-1:0]        gain_i,
  input  logic signed [pidbc_pkg::DATA_W-1:0] x_i,
  output logic                                done_o,
  output logic signed [pidbc_pkg::DATA_W-1:0] res_o
);
  import pidbc_pkg::*;

  logic               run_q, run_d, done_q, done_d;
  logic [4:0]         cnt_q, cnt_d;
  logic signed [32:0] hi_q, hi_d;
  logic [30:0]        lo_q, lo_d;
  logic signed [31:0] x_q, x_d;
  logic signed [33:0] sum;
  logic signed [63:0] shifted;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    x_d    = x_q;
    sum    = 34'(hi_q) + (lo_q[0] ? 34'(x_q) : 34'sd0);
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      hi_d  = '0;
      lo_d  = gain_i;
      x_d   = x_i;
    end else if (run_q) begin
      // shift-right multiply: add then drop one bit into the low half
      hi_d  = sum[33:1];
      lo_d  = {sum[0], lo_q[30:1]};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(GAIN_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
    x_q  <= x_d;
  end

  assign shifted = $signed({hi_q, lo_q}) >>> FracBits;
  assign done_o  = done_q;
  assign res_o   = (shifted[63:31] == {33{shifted[63]}}) ? shifted[31:0] :
                   (shifted[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

endmodule

FILE: rtl/pidbc_div.sv
// ----------------------------------------------------------------------------
// pidbc_div
// restoring divider for the derivative, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pidbc_div #(
  parameter int unsigned FracBits = pidbc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [32:0]                  diff_i,
  input  logic [pidbc_pkg::GAIN_W-1:0]        dt_i,
  output logic                                done_o,
  output logic signed [pidbc_pkg::DATA_W-1:0] res_o
);
  import pidbc_pkg::*;

  localparam int unsigned NumW = 33 + FracBits;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic              run_q, run_d, done_q, done_d, neg_q, neg_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [NumW-1:0]   num_q, num_d;
  logic [30:0]       rem_q, rem_d;
  logic [30:0]       dt_q, dt_d;
  logic [32:0]       mag;
  logic [31:0]       rem_sh, rem_sub;
  logic              ge;
  logic              big_pos, big_neg;

  always_comb begin
    mag     = diff_i[32] ? 33'(-diff_i) : 33'(diff_i);
    rem_sh  = {rem_q, num_q[NumW-1]};
    rem_sub = rem_sh - {1'b0, dt_q};
    ge      = rem_sh >= {1'b0, dt_q};
    run_d   = run_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    num_d   = num_q;
    rem_d   = rem_q;
    dt_d    = dt_q;
    neg_d   = neg_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      num_d = {mag, {FracBits{1'b0}}};
      rem_d = '0;
      dt_d  = dt_i;
      neg_d = diff_i[32];
    end else if (run_q) begin
      rem_d = ge ? rem_sub[30:0] : rem_sh[30:0];
      num_d = {num_q[NumW-2:0], ge};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(NumW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    dt_q  <= dt_d;
    neg_q <= neg_d;
  end

  // quotient magnitude sits in num_q, saturate after the sign
  assign big_pos = |num_q[NumW-1:31];
  assign big_neg = (|num_q[NumW-1:32]) || (num_q[31] && (|num_q[30:0]));
  assign done_o  = done_q;
  assign res_o   = neg_q ? (big_neg ? 32'sh8000_0000 : -$signed(num_q[31:0]))
                         : (big_pos ? 32'sh7FFF_FFFF : $signed(num_q[31:0]));

endmodule

FILE: rtl/pidbc_checker.sv
// ----------------------------------------------------------------------------
// pidbc_checker
// port-level checks of the pid unit, bound to the top level
// ----------------------------------------------------------------------------
module pidbc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] drive_i,
  input logic        hit_high_i,
  input logic        hit_low_i
);

  // a stalled drive beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(drive_i))
    else $error("drive beat dropped or changed while stalled");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(hit_high_i && hit_low_i))
    else $error("both clamp flags set");

  // one sample in flight: no second sample right after one is taken
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("sample taken while busy");

  // a new drive beat never shows up in the cycle after a sample is taken
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !out_valid_i |=> !out_valid_i)
    else $error("drive beat appeared too early");

endmodule

bind pid_controller_back_calc_antiwindup_unit pidbc_checker u_pidbc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_ch.valid),
  .in_ready_i (in_ch.ready),
  .out_valid_i(out_ch.valid),
  .out_ready_i(out_ch.ready),
  .drive_i    (out_ch.drive),
  .hit_high_i (out_ch.hit_high),
  .hit_low_i  (out_ch.hit_low)
);
